// File: rtl/core/ccs_pkg.sv
// Shared types and constants of the contour corner detector.
`default_nettype none
package ccs_pkg;

    localparam int COORD_BITS  = 12;
    localparam int POS_BITS    = 10;
    localparam int DIST_BITS   = 20;
    localparam int SHARP_BITS  = 16;
    localparam int OFFSET_BITS = 6;
    localparam int POINT_BITS  = 2 * COORD_BITS;
    localparam int SQ_BITS     = 2 * COORD_BITS + 1;
    localparam int ROOT_BITS   = SQ_BITS + 16;

    localparam logic CFG_SUPPORT_OFFSET      = 1'b0;
    localparam logic CFG_SHARPNESS_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [POS_BITS-1:0]   pos;
        logic                  valid;
        logic                  dropped;
        logic                  last;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_RDA,
        S_RDB,
        S_RDC,
        S_CAPC,
        S_SQA,
        S_SQB,
        S_ROOT,
        S_DINIT,
        S_DIV,
        S_EVAL,
        S_FIN
    } t_scan_state;

endpackage
`default_nettype wire

// File: rtl/core/ccs_ram.sv
// Generic single write, single read RAM with registered read data.
`default_nettype none
module ccs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/core/ccs_front.sv
// Point loader: accepts contour points, fills the point memory, starts the scan.
`default_nettype none
module ccs_front
    import ccs_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [COORD_BITS-1:0]         i_point_x,
    input  wire logic [COORD_BITS-1:0]         i_point_y,
    input  wire logic                          i_last_point,
    output logic                               o_we,
    output logic [$clog2(MAX_POINTS)-1:0]      o_waddr,
    output logic [POINT_BITS-1:0]              o_wdata,
    output logic                               o_start,
    output logic [$clog2(MAX_POINTS+1)-1:0]    o_n,
    input  wire logic                          i_done
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_busy;
    logic          r_start;
    logic          w_beat;
    logic          w_room;

    assign o_in_ready = !r_busy;
    assign w_beat     = i_in_valid && !r_busy;
    assign w_room     = r_count < CW'(MAX_POINTS);
    assign o_we       = w_beat && w_room;
    assign o_waddr    = r_count[AW-1:0];
    assign o_wdata    = {i_point_y, i_point_x};
    assign n_count    = w_room ? r_count + CW'(1) : r_count;
    assign o_start    = r_start;
    assign o_n        = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_done) begin
                r_busy  <= 1'b0;
                r_count <= '0;
            end else if (w_beat) begin
                r_count <= n_count;
                if (i_last_point) begin
                    r_busy  <= 1'b1;
                    r_start <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/ccs_fifo.sv
// Result queue between the scanner and the output channel.
`default_nettype none
module ccs_fifo
    import ccs_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    t_result       r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [NW-1:0] r_num;
    logic          w_pop;

    assign o_full  = r_num == NW'(DEPTH);
    assign o_valid = r_num != '0;
    assign o_data  = r_mem[r_rd];
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_num <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !w_pop) begin
                r_num <= r_num + NW'(1);
            end else if (w_pop && !i_push) begin
                r_num <= r_num - NW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/ccs_scan.sv
// Scanner: per point sharpness by bit-serial root and division, run tracking.
`default_nettype none
module ccs_scan
    import ccs_pkg::*;
#(
    parameter int MAX_POINTS  = 1024,
    parameter int MAX_CORNERS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [$clog2(MAX_POINTS+1)-1:0] i_n,
    input  wire logic [OFFSET_BITS-1:0]        i_offset,
    input  wire logic [SHARP_BITS-1:0]         i_threshold,
    output logic [$clog2(MAX_POINTS)-1:0]      o_raddr,
    input  wire logic [POINT_BITS-1:0]         i_rdata,
    output logic                               o_push,
    output t_result                            o_push_data,
    input  wire logic                          i_full,
    output logic                               o_done
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int KW = CW + OFFSET_BITS;
    localparam int FW = $clog2(MAX_CORNERS + 1);

    t_scan_state r_state;
    t_scan_state n_state;

    logic [CW-1:0]          r_n;
    logic [KW-1:0]          r_k;
    logic [AW-1:0]          r_i;
    logic [COORD_BITS-1:0]  r_pa_x, r_pa_y, r_pb_x, r_pb_y, r_pc_x, r_pc_y;
    logic [1:0]             r_di;
    logic [SQ_BITS-1:0]     r_sq;
    logic [ROOT_BITS-1:0]   r_v;
    logic [ROOT_BITS-1:0]   r_res;
    logic [ROOT_BITS-1:0]   r_bit;
    logic [DIST_BITS-1:0]   r_d0, r_d1, r_d2;
    logic [DIST_BITS:0]     r_arms;
    logic [DIST_BITS+1:0]   r_rem;
    logic [SHARP_BITS-1:0]  r_q;
    logic [3:0]             r_cnt;
    logic                   r_run;
    logic [SHARP_BITS-1:0]  r_best;
    logic [AW-1:0]          r_bpos;
    logic [COORD_BITS-1:0]  r_best_x, r_best_y;
    logic [FW-1:0]          r_found;
    logic                   r_drop;
    t_result                r_pend;
    logic                   r_pend_v;

    logic [CW-1:0]          w_kk;
    logic [CW:0]            w_ie, w_ia, w_sb, w_ib;
    logic                   w_final;
    logic [COORD_BITS-1:0]  w_p, w_q, w_dx, w_dy;
    logic [ROOT_BITS:0]     w_try;
    logic                   w_take;
    logic [ROOT_BITS-1:0]   w_res_n;
    logic [DIST_BITS-1:0]   w_dist;
    logic [DIST_BITS+1:0]   w_rem2;
    logic [SHARP_BITS-1:0]  w_sharp;
    logic                   w_above;
    logic                   w_emit;
    logic                   w_stall;
    t_result                w_new;

    assign w_kk    = r_k[CW-1:0];
    assign w_ie    = (CW+1)'(r_i);
    assign w_ia    = (w_ie >= {1'b0, w_kk}) ? w_ie - {1'b0, w_kk}
                                            : w_ie + {1'b0, r_n} - {1'b0, w_kk};
    assign w_sb    = w_ie + {1'b0, w_kk};
    assign w_ib    = (w_sb >= {1'b0, r_n}) ? w_sb - {1'b0, r_n} : w_sb;
    assign w_final = (w_ie + (CW+1)'(1)) == {1'b0, r_n};

    always_comb begin
        unique case (r_di)
            2'd0: begin
                w_p = r_pa_x; w_q = r_pb_x;
                w_dy = (r_pa_y > r_pb_y) ? r_pa_y - r_pb_y : r_pb_y - r_pa_y;
            end
            2'd1: begin
                w_p = r_pa_x; w_q = r_pc_x;
                w_dy = (r_pa_y > r_pc_y) ? r_pa_y - r_pc_y : r_pc_y - r_pa_y;
            end
            default: begin
                w_p = r_pb_x; w_q = r_pc_x;
                w_dy = (r_pb_y > r_pc_y) ? r_pb_y - r_pc_y : r_pc_y - r_pb_y;
            end
        endcase
        w_dx = (w_p > w_q) ? w_p - w_q : w_q - w_p;
    end

    assign w_try   = {1'b0, r_res} + {1'b0, r_bit};
    assign w_take  = {1'b0, r_v} >= w_try;
    assign w_res_n = w_take ? (r_res >> 1) + r_bit : r_res >> 1;
    assign w_dist  = (w_res_n > ROOT_BITS'({DIST_BITS{1'b1}})) ? {DIST_BITS{1'b1}}
                                                             : w_res_n[DIST_BITS-1:0];
    assign w_rem2  = {r_rem[DIST_BITS:0], 1'b0};

    always_comb begin
        if (r_arms == '0 || {1'b0, r_d0} >= r_arms) begin
            w_sharp = '0;
        end else if (r_q == '0) begin
            w_sharp = {SHARP_BITS{1'b1}};
        end else begin
            w_sharp = ~r_q + SHARP_BITS'(1);
        end
    end

    assign w_above = w_sharp > i_threshold;
    assign w_emit  = !w_above && r_run && (r_found < FW'(MAX_CORNERS));
    assign w_stall = w_emit && r_pend_v && i_full;

    always_comb begin
        w_new.x       = r_best_x;
        w_new.y       = r_best_y;
        w_new.pos     = POS_BITS'(r_bpos);
        w_new.valid   = 1'b1;
        w_new.dropped = 1'b0;
        w_new.last    = 1'b0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_MOD;
            S_MOD:   if (r_k < KW'(r_n)) n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_RDC;
            S_RDC:   n_state = S_CAPC;
            S_CAPC:  n_state = S_SQA;
            S_SQA:   n_state = S_SQB;
            S_SQB:   n_state = S_ROOT;
            S_ROOT: begin
                if (r_bit[0]) n_state = (r_di == 2'd2) ? S_DINIT : S_SQA;
            end
            S_DINIT: n_state = S_DIV;
            S_DIV:   if (r_cnt == 4'd15) n_state = S_EVAL;
            S_EVAL: begin
                if (!w_stall) n_state = w_final ? S_FIN : S_RDA;
            end
            S_FIN:   if (!i_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_raddr     = r_i;
        o_push      = 1'b0;
        o_push_data = r_pend;
        o_done      = 1'b0;
        unique case (r_state)
            S_RDA: o_raddr = w_ia[AW-1:0];
            S_RDB: o_raddr = w_ib[AW-1:0];
            S_EVAL: o_push = w_emit && r_pend_v && !i_full;
            S_FIN: begin
                o_push = !i_full;
                o_done = !i_full;
                if (r_pend_v) begin
                    o_push_data.dropped = r_drop;
                end else begin
                    o_push_data = '0;
                end
                o_push_data.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_run    <= 1'b0;
            r_found  <= '0;
            r_drop   <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EVAL && !w_stall) begin
                if (w_above) begin
                    r_run <= 1'b1;
                end else if (r_run) begin
                    r_run <= 1'b0;
                    if (w_emit) begin
                        r_found  <= r_found + FW'(1);
                        r_pend_v <= 1'b1;
                    end else begin
                        r_drop <= 1'b1;
                    end
                end
            end
            if (r_state == S_FIN && !i_full) begin
                r_run    <= 1'b0;
                r_found  <= '0;
                r_drop   <= 1'b0;
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n <= i_n;
                r_k <= KW'(i_offset);
                r_i <= '0;
            end
            S_MOD: if (r_k >= KW'(r_n)) r_k <= r_k - KW'(r_n);
            S_RDB: {r_pa_y, r_pa_x} <= i_rdata;
            S_RDC: {r_pb_y, r_pb_x} <= i_rdata;
            S_CAPC: begin
                {r_pc_y, r_pc_x} <= i_rdata;
                r_di <= 2'd0;
            end
            S_SQA: r_sq <= SQ_BITS'(w_dx * w_dx);
            S_SQB: begin
                r_v   <= {r_sq + SQ_BITS'(w_dy * w_dy), 16'd0};
                r_res <= '0;
                r_bit <= ROOT_BITS'(1) << (ROOT_BITS - 1);
            end
            S_ROOT: begin
                if (w_take) r_v <= r_v - w_try[ROOT_BITS-1:0];
                r_res <= w_res_n;
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    unique case (r_di)
                        2'd0:    r_d0 <= w_dist;
                        2'd1:    r_d1 <= w_dist;
                        default: r_d2 <= w_dist;
                    endcase
                    r_di <= r_di + 2'd1;
                end
            end
            S_DINIT: begin
                r_arms <= {1'b0, r_d1} + {1'b0, r_d2};
                r_rem  <= (DIST_BITS+2)'(r_d0);
                r_q    <= '0;
                r_cnt  <= '0;
            end
            S_DIV: begin
                if (w_rem2 >= {1'b0, r_arms}) begin
                    r_rem <= w_rem2 - {1'b0, r_arms};
                    r_q   <= {r_q[SHARP_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem2;
                    r_q   <= {r_q[SHARP_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 4'd1;
            end
            S_EVAL: begin
                if (!w_stall) begin
                    if (w_above) begin
                        if (!r_run || w_sharp > r_best) begin
                            r_best   <= w_sharp;
                            r_bpos   <= r_i;
                            r_best_x <= r_pc_x;
                            r_best_y <= r_pc_y;
                        end
                    end else if (r_run) begin
                        if (w_emit) r_pend <= w_new;
                        r_best <= '0;
                        r_bpos <= '0;
                    end
                    r_i <= r_i + AW'(1);
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/contour_corner_by_chord_sharpness.sv
// Top level of the contour corner detector.
//
// Input channel (i_in_valid / o_in_ready): one contour point per beat. Points
// load into the point memory at one per cycle while o_in_ready is high. A beat
// with i_last_point set closes the contour and starts the scan; o_in_ready
// stays low until the scan has queued its last result.
// Scan: per stored point, three memory reads, three distances each through a
// 21 step bit-serial square root, then a 16 step divider, on the shared root
// and divider units of the scanner; first the point count is subtracted from
// the support offset until it wraps, and a closing state ends the scan.
// Output channel (o_out_valid / i_out_ready): one beat per corner, or one
// beat with o_corner_valid low when none is found; o_last_result marks the
// final beat. A four entry result queue parts scanner and receiver; the scan
// holds only while that queue is full.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data): write only while idle (not enforced).
// Reset (synchronous, active low) clears counters, run state and the queue,
// and loads support offset 5 and threshold 5243; the point memory is not
// cleared and needs no clearing pass.
`default_nettype none
module contour_corner_by_chord_sharpness
    import ccs_pkg::*;
#(
    parameter int MAX_POINTS  = 1024,
    parameter int MAX_CORNERS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [COORD_BITS-1:0] i_point_x,
    input  wire logic [COORD_BITS-1:0] i_point_y,
    input  wire logic                  i_last_point,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [COORD_BITS-1:0]      o_corner_x,
    output logic [COORD_BITS-1:0]      o_corner_y,
    output logic [POS_BITS-1:0]        o_corner_position,
    output logic                       o_corner_valid,
    output logic                       o_corners_dropped,
    output logic                       o_last_result,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_index,
    input  wire logic [SHARP_BITS-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [OFFSET_BITS-1:0] r_offset;
    logic [SHARP_BITS-1:0]  r_threshold;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [POINT_BITS-1:0] w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [POINT_BITS-1:0] w_rdata;
    logic                  w_start;
    logic [CW-1:0]         w_n;
    logic                  w_done;
    logic                  w_push;
    t_result               w_push_data;
    logic                  w_full;
    t_result               w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= OFFSET_BITS'(5);
            r_threshold <= SHARP_BITS'(5243);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SUPPORT_OFFSET:      r_offset    <= i_cfg_data[OFFSET_BITS-1:0];
                CFG_SHARPNESS_THRESHOLD: r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ccs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_start      (w_start),
        .o_n          (w_n),
        .i_done       (w_done)
    );

    ccs_ram #(.WIDTH(POINT_BITS), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ccs_scan #(.MAX_POINTS(MAX_POINTS), .MAX_CORNERS(MAX_CORNERS)) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_n         (w_n),
        .i_offset    (r_offset),
        .i_threshold (r_threshold),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_full      (w_full),
        .o_done      (w_done)
    );

    ccs_fifo #(.DEPTH(4)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_out)
    );

    assign o_corner_x        = w_out.x;
    assign o_corner_y        = w_out.y;
    assign o_corner_position = w_out.pos;
    assign o_corner_valid    = w_out.valid;
    assign o_corners_dropped = w_out.dropped;
    assign o_last_result     = w_out.last;

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the contour corner detector: contours in, corners checked out.
module tb_top;
    import ccs_pkg::*;

    localparam int STORE_DEPTH  = 1024;
    localparam int CORNER_LIMIT = 32;
    localparam int STALL_LIMIT  = 400000;
    localparam int SETTLE       = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [COORD_BITS-1:0] i_point_x;
    logic [COORD_BITS-1:0] i_point_y;
    logic                  i_last_point;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [COORD_BITS-1:0] o_corner_x;
    logic [COORD_BITS-1:0] o_corner_y;
    logic [POS_BITS-1:0]   o_corner_position;
    logic                  o_corner_valid;
    logic                  o_corners_dropped;
    logic                  o_last_result;
    logic                  i_cfg_we;
    logic                  i_cfg_index;
    logic [SHARP_BITS-1:0] i_cfg_data;

    contour_corner_by_chord_sharpness uut (.*);

    // Predictor state
    logic [COORD_BITS-1:0] pts_x [STORE_DEPTH];
    logic [COORD_BITS-1:0] pts_y [STORE_DEPTH];
    int unsigned           loaded_points;
    logic [5:0]            support_k;
    logic [15:0]           sharp_floor;
    t_result               corner_queue [$];

    int  mismatches;
    int  points_sent;
    int  contours_sent;
    int  corners_seen;
    int  stall_cycles;
    int  hold_left;
    bit  calm;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned span_q8(int unsigned a, int unsigned b);
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned d;
        dx = pts_x[a] > pts_x[b] ? pts_x[a] - pts_x[b] : pts_x[b] - pts_x[a];
        dy = pts_y[a] > pts_y[b] ? pts_y[a] - pts_y[b] : pts_y[b] - pts_y[a];
        d = int_sqrt((dx * dx + dy * dy) << 16);
        return d > 64'hFFFFF ? 64'hFFFFF : d;
    endfunction

    function automatic int unsigned chord_sharpness(int unsigned i, int unsigned n);
        int unsigned     k;
        int unsigned     ia;
        int unsigned     ib;
        longint unsigned chord;
        longint unsigned arms;
        longint unsigned r;
        k = support_k % n;
        ia = (i + n - k) % n;
        ib = (i + k) % n;
        chord = span_q8(ia, ib);
        arms = span_q8(ia, i) + span_q8(ib, i);
        if (arms == 0) return 0;
        r = (chord << 16) / arms;
        if (r >= 65536) return 0;
        if (r == 0) return 65535;
        return 32'(65536 - r);
    endfunction

    // Advance the predictor by one accepted point; on the last one, scan and queue corners.
    task automatic predict_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                 logic last);
        int unsigned n;
        int unsigned s;
        int unsigned best_s;
        int unsigned best_i;
        int          found;
        bit          in_run;
        bit          dropped;
        t_result     r;
        if (loaded_points < STORE_DEPTH) begin
            pts_x[loaded_points] = x;
            pts_y[loaded_points] = y;
            loaded_points++;
        end
        if (!last) return;
        n = loaded_points;
        in_run = 0;
        best_s = 0;
        best_i = 0;
        found = 0;
        dropped = 0;
        for (int unsigned i = 0; i < n; i++) begin
            s = chord_sharpness(i, n);
            if (s > sharp_floor) begin
                if (!in_run || s > best_s) begin
                    best_s = s;
                    best_i = i;
                end
                in_run = 1;
            end else if (in_run) begin
                if (found < CORNER_LIMIT) begin
                    r = '0;
                    r.x = pts_x[best_i];
                    r.y = pts_y[best_i];
                    r.pos = best_i[POS_BITS-1:0];
                    r.valid = 1'b1;
                    corner_queue.insert(corner_queue.size(), r);
                    found++;
                end else begin
                    dropped = 1;
                end
                in_run = 0;
                best_s = 0;
                best_i = 0;
            end
        end
        if (found == 0) begin
            r = '0;
            corner_queue.insert(corner_queue.size(), r);
        end
        corner_queue[$].dropped = dropped;
        corner_queue[$].last = 1'b1;
        loaded_points = 0;
        contours_sent++;
    endtask

    task automatic send_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y, logic last);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 13) begin
            gap = $urandom_range(4, 1);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_point_x    <= x;
        i_point_y    <= y;
        i_last_point <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_point(x, y, last);
        points_sent++;
    endtask

    task automatic send_contour(logic [2*COORD_BITS-1:0] pts [$]);
        foreach (pts[i]) send_point(pts[i][2*COORD_BITS-1:COORD_BITS],
                                    pts[i][COORD_BITS-1:0], i == pts.size() - 1);
    endtask

    // Drop valid and wait out every expected corner plus the block's tail.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (corner_queue.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [SHARP_BITS-1:0] data);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_SUPPORT_OFFSET) support_k = data[5:0];
        else sharp_floor = data;
    endtask

    task automatic make_polygon(output logic [2*COORD_BITS-1:0] pts [$], input int span);
        int vx [8];
        int vy [8];
        int nv;
        int steps;
        int bx;
        int by;
        pts = {};
        nv = $urandom_range(8, 3);
        bx = $urandom_range(4095 - span);
        by = $urandom_range(4095 - span);
        for (int v = 0; v < nv; v++) begin
            vx[v] = bx + $urandom_range(span);
            vy[v] = by + $urandom_range(span);
        end
        for (int v = 0; v < nv; v++) begin
            steps = $urandom_range(7, 2);
            for (int s = 0; s < steps; s++) begin
                pts.insert(pts.size(),
                           {12'(vx[v] + (vx[(v + 1) % nv] - vx[v]) * s / steps),
                            12'(vy[v] + (vy[(v + 1) % nv] - vy[v]) * s / steps)});
            end
        end
    endtask

    task automatic test_square_defaults();
        logic [2*COORD_BITS-1:0] pts [$];
        pts = {};
        for (int s = 0; s < 5; s++) pts.insert(pts.size(), {12'(s * 819), 12'd0});
        for (int s = 0; s < 5; s++) pts.insert(pts.size(), {12'd4095, 12'(s * 819)});
        for (int s = 0; s < 5; s++) pts.insert(pts.size(), {12'(4095 - s * 819), 12'd4095});
        for (int s = 0; s < 5; s++) pts.insert(pts.size(), {12'd0, 12'(4095 - s * 819)});
        send_contour(pts);
        drain();
    endtask

    task automatic test_special_cases();
        logic [2*COORD_BITS-1:0] pts [$];
        // coincident points: zero arm sum
        pts = '{{12'd100, 12'd200}, {12'd100, 12'd200}, {12'd100, 12'd200}};
        send_contour(pts);
        // single point: offset wraps to zero
        pts = '{{12'hFFF, 12'hFFF}};
        send_contour(pts);
        drain();
        // offset equal to half the count: zero chord
        write_cfg(CFG_SUPPORT_OFFSET, 16'd5);
        write_cfg(CFG_SHARPNESS_THRESHOLD, 16'd0);
        pts = {};
        for (int i = 0; i < 10; i++)
            pts.insert(pts.size(), {12'(i * 37), 12'((i % 3) * 300)});
        send_contour(pts);
        drain();
        // offset past the count, top threshold
        write_cfg(CFG_SUPPORT_OFFSET, 16'd63);
        write_cfg(CFG_SHARPNESS_THRESHOLD, 16'hFFFF);
        pts = '{{12'd0, 12'd0}, {12'd4095, 12'd0}, {12'd4095, 12'd4095}, {12'd0, 12'd4095},
                {12'd2048, 12'd1}, {12'd1, 12'd2048}, {12'd7, 12'd9}};
        send_contour(pts);
        drain();
        write_cfg(CFG_SUPPORT_OFFSET, 16'd1);
        write_cfg(CFG_SHARPNESS_THRESHOLD, 16'd5243);
    endtask

    task automatic test_corner_overflow();
        logic [2*COORD_BITS-1:0] pts [$];
        pts = {};
        for (int i = 0; i < 144; i++)
            pts.insert(pts.size(), {12'(i * 8), 12'((i % 4 == 2) ? 40 : 0)});
        calm = 1;
        send_contour(pts);
        drain();
        calm = 0;
    endtask

    task automatic test_backpressure();
        logic [2*COORD_BITS-1:0] pts [$];
        write_cfg(CFG_SUPPORT_OFFSET, 16'd1);
        hold_left = 6000;
        pts = {};
        for (int i = 0; i < 40; i++)
            pts.insert(pts.size(), {12'(i * 8), 12'((i % 4 == 2) ? 40 : 0)});
        send_contour(pts);
        make_polygon(pts, 600);
        send_contour(pts);
        drain();
    endtask

    task automatic test_random_contours(int budget);
        logic [2*COORD_BITS-1:0] pts [$];
        int start;
        int pick;
        start = points_sent;
        while (points_sent - start < budget) begin
            pick = $urandom_range(99);
            case ($urandom_range(5))
                0: write_cfg(CFG_SUPPORT_OFFSET, 16'(pick < 50 ? 1 : 63));
                1: write_cfg(CFG_SUPPORT_OFFSET, 16'($urandom_range(6, 1)));
                2: write_cfg(CFG_SHARPNESS_THRESHOLD, 16'($urandom_range(65535)));
                3: write_cfg(CFG_SHARPNESS_THRESHOLD, 16'($urandom_range(20000)));
                default: ;
            endcase
            calm = ($urandom_range(9) == 0);
            if (pick < 75) begin
                make_polygon(pts, pick < 20 ? 4095 : $urandom_range(400, 20));
            end else if (pick < 90) begin
                pts = {};
                repeat ($urandom_range(12, 1))
                    pts.insert(pts.size(),
                               {12'($urandom_range(4095)), 12'($urandom_range(4095))});
            end else begin
                pts = {};
                repeat ($urandom_range(8, 2))
                    pts.insert(pts.size(),
                               {12'($urandom_range(3) * 2000), 12'($urandom_range(1))});
            end
            send_contour(pts);
            if ($urandom_range(3) == 0) drain();
        end
        calm = 0;
        drain();
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (corner_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat");
                end else begin
                    exp_r = corner_queue.pop_front();
                    corners_seen++;
                    if (o_corner_x !== exp_r.x || o_corner_y !== exp_r.y
                        || o_corner_position !== exp_r.pos || o_corner_valid !== exp_r.valid
                        || o_corners_dropped !== exp_r.dropped
                        || o_last_result !== exp_r.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("mismatch: exp x=%0d y=%0d pos=%0d v=%b d=%b l=%b, ",
                                   exp_r.x, exp_r.y, exp_r.pos, exp_r.valid, exp_r.dropped,
                                   exp_r.last);
                            $display("got x=%0d y=%0d pos=%0d v=%b d=%b l=%b",
                                     o_corner_x, o_corner_y, o_corner_position,
                                     o_corner_valid, o_corners_dropped, o_last_result);
                        end
                    end
                end
            end
            if (stall_cycles > STALL_LIMIT) begin
                $display("watchdog expired");
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_point_x = '0;
        i_point_y = '0;
        i_last_point = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_SUPPORT_OFFSET;
        i_cfg_data = '0;
        loaded_points = 0;
        support_k = 6'd5;
        sharp_floor = 16'd5243;
        mismatches = 0;
        points_sent = 0;
        contours_sent = 0;
        corners_seen = 0;
        stall_cycles = 0;
        hold_left = 0;
        calm = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_square_defaults();
        test_special_cases();
        test_corner_overflow();
        test_backpressure();
        calm = 1;
        test_random_contours(50);
        calm = 0;
        test_random_contours(110);

        repeat (SETTLE) @(negedge i_clk);
        $display("covered %0d points in %0d contours, %0d result beats checked",
                 points_sent, contours_sent, corners_seen);
        $display("including corner overflow, output stalls and config extremes");
        if (mismatches == 0 && corner_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: contour_corner_by_chord_sharpness.f
rtl/core/ccs_pkg.sv
rtl/core/ccs_ram.sv
rtl/core/ccs_front.sv
rtl/core/ccs_fifo.sv
rtl/core/ccs_scan.sv
rtl/core/contour_corner_by_chord_sharpness.sv
verif/tb_top.sv
